>>> rtl/core/floppy_dma_sync_controller_top_defines.svh
// Assertion macros shared by the floppy DMA sync controller RTL.
`ifndef FLOPPY_DMA_SYNC_CONTROLLER_TOP_DEFINES_SVH
`define FLOPPY_DMA_SYNC_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FDSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdsc: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FDSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdsc: next-cycle check failed");

`endif

>>> rtl/core/fdsc_pkg.sv
// Types and constants of the floppy DMA sync controller.
package fdsc_pkg;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] reg_value;
        logic        word_sync;
        logic        drive_selected;
        logic [7:0]  drive_byte_a;
        logic [7:0]  drive_byte_b;
        logic [15:0] mem_word;
        logic [47:0] now_clock;
        logic        disk_dma_on;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] payload;
        logic        last;
    } out_item_t;

    // Item modes
    localparam logic [2:0] MODE_WR_LEN    = 3'd0;
    localparam logic [2:0] MODE_WR_SYNC   = 3'd1;
    localparam logic [2:0] MODE_RD_STATUS = 3'd2;
    localparam logic [2:0] MODE_DISK_TICK = 3'd3;
    localparam logic [2:0] MODE_DMA_SLOT  = 3'd4;

    // Result kinds
    localparam logic [2:0] KIND_STATUS     = 3'd0;
    localparam logic [2:0] KIND_SYNC_IRQ   = 3'd1;
    localparam logic [2:0] KIND_BLOCK_DONE = 3'd2;
    localparam logic [2:0] KIND_MEM_WORD   = 3'd3;
    localparam logic [2:0] KIND_DISK_BYTE  = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_ASYNC_FIFO = 2'd0;
    localparam logic [1:0] CFG_LOCK_SYNC  = 2'd1;
    localparam logic [1:0] CFG_AUTO_SYNC  = 2'd2;

    localparam logic [15:0] SYNC_DEFAULT = 16'h4489;
    localparam logic [14:0] MISS_LIMIT   = 15'd20000;
    localparam logic [47:0] AGE_LIMIT    = 48'd7;

    typedef enum logic [1:0] {
        DMA_OFF   = 2'd0,
        DMA_WAIT  = 2'd1,
        DMA_READ  = 2'd2,
        DMA_WRITE = 2'd3
    } dma_state_t;

    typedef enum logic [2:0] {
        C_IDLE   = 3'd0,
        C_DECODE = 3'd1,
        C_STEP_A = 3'd2,
        C_STEP_B = 3'd3,
        C_XFER   = 3'd4,
        C_DONE   = 3'd5,
        C_FLUSH  = 3'd6,
        C_FIN    = 3'd7
    } ctrl_state_t;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_LOAD    = 4'd1,
        CMD_WR_LEN  = 4'd2,
        CMD_WR_SYNC = 4'd3,
        CMD_STATUS  = 4'd4,
        CMD_STEP_A  = 4'd5,
        CMD_STEP_B  = 4'd6,
        CMD_XFER    = 4'd7,
        CMD_DONE    = 4'd8,
        CMD_FLUSH   = 4'd9,
        CMD_FIN     = 4'd10
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       async_latched;
        logic       xfer_zero;
        logic       st_write;
        logic       fill_zero;
        logic       fill_one;
        logic       out_free;
        logic       hold_valid;
    } dp_status_t;

endpackage

>>> rtl/core/fdsc_dp.sv
// Datapath: item register, FIFO, DMA state, registers and result output stage.
module fdsc_dp #(
    parameter int FIFO_BYTES = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fdsc_pkg::cmd_t       cmd,
    input  fdsc_pkg::in_item_t   in_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic                 cfg_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output fdsc_pkg::out_item_t  out_item,
    output fdsc_pkg::dp_status_t status
);

    localparam int FW = $clog2(FIFO_BYTES + 1);
    localparam int IW = $clog2(FIFO_BYTES);
    localparam int DW = 8 * FIFO_BYTES;
    localparam logic [FW-1:0] FILL_MAX  = FW'(FIFO_BYTES);
    localparam logic [FW-1:0] FILL_MAX2 = FW'(FIFO_BYTES - 2);
    localparam logic [FW-1:0] FILL_ONE  = FW'(1);
    localparam logic [FW-1:0] FILL_TWO  = FW'(2);

    fdsc_pkg::in_item_t   item_reg, item_next;
    fdsc_pkg::dma_state_t dma_state_reg, dma_state_next;
    logic [15:0]   length_reg, length_next;
    logic [15:0]   sync_word_reg, sync_word_next;
    logic [DW-1:0] fifo_bytes_reg, fifo_bytes_next;
    logic [FW-1:0] fifo_fill_reg, fifo_fill_next;
    logic [7:0]    last_byte_reg, last_byte_next;
    logic [47:0]   last_time_reg, last_time_next;
    logic          sync_seen_reg, sync_seen_next;
    logic [14:0]   miss_reg, miss_next;
    logic          async_latched_reg, async_latched_next;
    logic          async_fifo_reg, lock_sync_reg, auto_sync_reg;

    logic          out_valid_reg, out_valid_next;
    fdsc_pkg::out_item_t out_reg, out_next;
    logic          hold_valid_reg, hold_valid_next;
    logic [2:0]    hold_kind_reg, hold_kind_next;
    logic [15:0]   hold_payload_reg, hold_payload_next;

    logic          emit_valid;
    logic [2:0]    emit_kind;
    logic [15:0]   emit_payload;
    logic          xfer_zero;
    logic [7:0]    step_byte;
    logic [FW-1:0] push_fill;
    logic [DW-1:0] push_bytes;
    logic          push_match;
    logic [IW-1:0] pop1_idx;
    logic [IW-1:0] pop2_idx;
    logic [7:0]    pop_byte;
    logic [15:0]   pop_word;
    logic [15:0]   length_dec;
    logic [47:0]   byte_age;
    logic          hit;
    logic          out_free;

    assign step_byte  = (cmd == fdsc_pkg::CMD_STEP_B) ? item_reg.drive_byte_b
                                                     : item_reg.drive_byte_a;
    // A full FIFO drops its oldest two bytes before the push.
    assign push_fill  = ((fifo_fill_reg >= FILL_MAX) ? FILL_MAX2 : fifo_fill_reg) + FILL_ONE;
    assign push_bytes = {fifo_bytes_reg[DW-9:0], step_byte};
    assign push_match = (push_fill >= FILL_TWO) && (push_bytes[15:0] == sync_word_reg);
    assign pop1_idx   = IW'(fifo_fill_reg - FILL_ONE);
    assign pop2_idx   = IW'(fifo_fill_reg - FILL_TWO);
    assign pop_byte   = fifo_bytes_reg[8*pop1_idx +: 8];
    assign pop_word   = fifo_bytes_reg[8*pop2_idx +: 16];
    assign length_dec = length_reg - 16'd1;
    assign byte_age   = item_reg.now_clock - last_time_reg;
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        item_next          = item_reg;
        dma_state_next     = dma_state_reg;
        length_next        = length_reg;
        sync_word_next     = sync_word_reg;
        fifo_bytes_next    = fifo_bytes_reg;
        fifo_fill_next     = fifo_fill_reg;
        last_byte_next     = last_byte_reg;
        last_time_next     = last_time_reg;
        sync_seen_next     = sync_seen_reg;
        miss_next          = miss_reg;
        async_latched_next = async_latched_reg;
        emit_valid         = 1'b0;
        emit_kind          = fdsc_pkg::KIND_STATUS;
        emit_payload       = 16'd0;
        xfer_zero          = 1'b0;
        hit                = 1'b0;
        case (cmd)
            fdsc_pkg::CMD_LOAD:
            begin
                item_next = in_item;
            end
            fdsc_pkg::CMD_WR_LEN:
            begin
                length_next        = item_reg.reg_value;
                async_latched_next = async_fifo_reg;
                if (!item_reg.reg_value[15])
                begin
                    dma_state_next  = fdsc_pkg::DMA_OFF;
                    fifo_bytes_next = '0;
                    fifo_fill_next  = '0;
                end
                else if (length_reg[15])
                begin
                    // Second enable write: pick the transfer direction.
                    if (length_reg[14] && item_reg.reg_value[14])
                        dma_state_next = fdsc_pkg::DMA_WRITE;
                    else if (item_reg.word_sync)
                        dma_state_next = fdsc_pkg::DMA_WAIT;
                    else
                        dma_state_next = fdsc_pkg::DMA_READ;
                    fifo_bytes_next = '0;
                    fifo_fill_next  = '0;
                end
            end
            fdsc_pkg::CMD_WR_SYNC:
            begin
                if (!(item_reg.reg_value != fdsc_pkg::SYNC_DEFAULT && lock_sync_reg))
                    sync_word_next = item_reg.reg_value;
            end
            fdsc_pkg::CMD_STATUS:
            begin
                emit_valid   = 1'b1;
                emit_kind    = fdsc_pkg::KIND_STATUS;
                emit_payload = {byte_age <= fdsc_pkg::AGE_LIMIT,
                                item_reg.disk_dma_on && (dma_state_reg != fdsc_pkg::DMA_OFF),
                                length_reg[14], sync_seen_reg, 4'd0, last_byte_reg};
            end
            fdsc_pkg::CMD_STEP_A, fdsc_pkg::CMD_STEP_B:
            begin
                if (item_reg.drive_selected)
                begin
                    if (dma_state_reg != fdsc_pkg::DMA_WRITE)
                    begin
                        last_byte_next  = step_byte;
                        last_time_next  = item_reg.now_clock;
                        fifo_bytes_next = push_bytes;
                        fifo_fill_next  = push_fill;
                        sync_seen_next  = push_match;
                        hit             = push_match;
                        if (!push_match && auto_sync_reg)
                        begin
                            hit       = miss_reg > fdsc_pkg::MISS_LIMIT;
                            miss_next = miss_reg + 15'd1;
                        end
                        if (hit)
                        begin
                            emit_valid = 1'b1;
                            emit_kind  = fdsc_pkg::KIND_SYNC_IRQ;
                            if (dma_state_reg == fdsc_pkg::DMA_WAIT)
                            begin
                                dma_state_next  = fdsc_pkg::DMA_READ;
                                fifo_bytes_next = '0;
                                fifo_fill_next  = '0;
                            end
                            miss_next = 15'd0;
                        end
                    end
                    else if (fifo_fill_reg != '0)
                    begin
                        emit_valid     = 1'b1;
                        emit_kind      = fdsc_pkg::KIND_DISK_BYTE;
                        emit_payload   = {8'd0, pop_byte};
                        fifo_fill_next = fifo_fill_reg - FILL_ONE;
                    end
                end
            end
            fdsc_pkg::CMD_XFER:
            begin
                if ((length_reg[13:0] != 14'd0) && item_reg.drive_selected)
                begin
                    if ((dma_state_reg == fdsc_pkg::DMA_READ) && (fifo_fill_reg >= FILL_TWO))
                    begin
                        emit_valid     = 1'b1;
                        emit_kind      = fdsc_pkg::KIND_MEM_WORD;
                        emit_payload   = pop_word;
                        fifo_fill_next = fifo_fill_reg - FILL_TWO;
                        length_next    = length_dec;
                        xfer_zero      = length_dec[13:0] == 14'd0;
                    end
                    else if ((dma_state_reg == fdsc_pkg::DMA_WRITE) &&
                             (fifo_fill_reg <= FILL_MAX2))
                    begin
                        fifo_bytes_next = {fifo_bytes_reg[DW-17:0], item_reg.mem_word};
                        fifo_fill_next  = fifo_fill_reg + FILL_TWO;
                        length_next     = length_dec;
                        xfer_zero       = length_dec[13:0] == 14'd0;
                    end
                end
            end
            fdsc_pkg::CMD_DONE:
            begin
                emit_valid     = 1'b1;
                emit_kind      = fdsc_pkg::KIND_BLOCK_DONE;
                dma_state_next = fdsc_pkg::DMA_OFF;
            end
            fdsc_pkg::CMD_FLUSH:
            begin
                emit_valid     = 1'b1;
                emit_kind      = fdsc_pkg::KIND_DISK_BYTE;
                emit_payload   = {8'd0, pop_byte};
                fifo_fill_next = fifo_fill_reg - FILL_ONE;
            end
            default:
            begin
            end
        endcase
    end

    // The newest result waits in the hold stage until the next one or the
    // end of the item shows whether it is the last.
    always_comb
    begin
        out_valid_next    = out_valid_reg && out_stall;
        out_next          = out_reg;
        hold_valid_next   = hold_valid_reg;
        hold_kind_next    = hold_kind_reg;
        hold_payload_next = hold_payload_reg;
        if (emit_valid)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = '{kind: hold_kind_reg, payload: hold_payload_reg, last: 1'b0};
            end
            hold_valid_next   = 1'b1;
            hold_kind_next    = emit_kind;
            hold_payload_next = emit_payload;
        end
        else if ((cmd == fdsc_pkg::CMD_FIN) && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = '{kind: hold_kind_reg, payload: hold_payload_reg, last: 1'b1};
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dma_state_reg     <= fdsc_pkg::DMA_OFF;
            length_reg        <= 16'd0;
            sync_word_reg     <= fdsc_pkg::SYNC_DEFAULT;
            fifo_bytes_reg    <= '0;
            fifo_fill_reg     <= '0;
            last_byte_reg     <= 8'd0;
            last_time_reg     <= 48'd0;
            sync_seen_reg     <= 1'b0;
            miss_reg          <= 15'd0;
            async_latched_reg <= 1'b1;
            async_fifo_reg    <= 1'b1;
            lock_sync_reg     <= 1'b0;
            auto_sync_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            hold_valid_reg    <= 1'b0;
        end
        else
        begin
            dma_state_reg     <= dma_state_next;
            length_reg        <= length_next;
            sync_word_reg     <= sync_word_next;
            fifo_bytes_reg    <= fifo_bytes_next;
            fifo_fill_reg     <= fifo_fill_next;
            last_byte_reg     <= last_byte_next;
            last_time_reg     <= last_time_next;
            sync_seen_reg     <= sync_seen_next;
            miss_reg          <= miss_next;
            async_latched_reg <= async_latched_next;
            out_valid_reg     <= out_valid_next;
            hold_valid_reg    <= hold_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    fdsc_pkg::CFG_ASYNC_FIFO: async_fifo_reg <= cfg_data;
                    fdsc_pkg::CFG_LOCK_SYNC:  lock_sync_reg  <= cfg_data;
                    fdsc_pkg::CFG_AUTO_SYNC:  auto_sync_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        out_reg          <= out_next;
        hold_kind_reg    <= hold_kind_next;
        hold_payload_reg <= hold_payload_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign status.mode          = item_reg.mode;
    assign status.async_latched = async_latched_reg;
    assign status.xfer_zero     = xfer_zero;
    assign status.st_write      = dma_state_reg == fdsc_pkg::DMA_WRITE;
    assign status.fill_zero     = fifo_fill_reg == '0;
    assign status.fill_one      = fifo_fill_reg == FILL_ONE;
    assign status.out_free      = out_free;
    assign status.hold_valid    = hold_valid_reg;

endmodule

>>> rtl/core/fdsc_ctrl.sv
// Sequencer: walks one item through its FIFO steps, transfer and result flush.
module fdsc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  fdsc_pkg::dp_status_t status,
    output logic                 in_stall,
    output fdsc_pkg::cmd_t       cmd
);

    fdsc_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fdsc_pkg::C_IDLE:
            begin
                if (in_valid)
                    state_next = fdsc_pkg::C_DECODE;
            end
            fdsc_pkg::C_DECODE:
            begin
                if (status.out_free)
                begin
                    case (status.mode)
                        fdsc_pkg::MODE_DISK_TICK:
                            state_next = status.async_latched ? fdsc_pkg::C_STEP_A
                                                              : fdsc_pkg::C_FIN;
                        fdsc_pkg::MODE_DMA_SLOT:
                            state_next = status.async_latched ? fdsc_pkg::C_XFER
                                                              : fdsc_pkg::C_STEP_A;
                        default:
                            state_next = fdsc_pkg::C_FIN;
                    endcase
                end
            end
            fdsc_pkg::C_STEP_A:
            begin
                if (status.out_free)
                    state_next = (status.mode == fdsc_pkg::MODE_DMA_SLOT) ? fdsc_pkg::C_STEP_B
                                                                         : fdsc_pkg::C_FIN;
            end
            fdsc_pkg::C_STEP_B:
            begin
                if (status.out_free)
                    state_next = fdsc_pkg::C_XFER;
            end
            fdsc_pkg::C_XFER:
            begin
                if (status.out_free)
                    state_next = status.xfer_zero ? fdsc_pkg::C_DONE : fdsc_pkg::C_FIN;
            end
            fdsc_pkg::C_DONE:
            begin
                if (status.out_free)
                    state_next = (status.st_write && !status.fill_zero) ? fdsc_pkg::C_FLUSH
                                                                        : fdsc_pkg::C_FIN;
            end
            fdsc_pkg::C_FLUSH:
            begin
                if (status.out_free && status.fill_one)
                    state_next = fdsc_pkg::C_FIN;
            end
            fdsc_pkg::C_FIN:
            begin
                if (status.out_free)
                    state_next = fdsc_pkg::C_IDLE;
            end
            default:
            begin
                state_next = fdsc_pkg::C_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = fdsc_pkg::CMD_NONE;
        case (state_reg)
            fdsc_pkg::C_IDLE:
            begin
                if (in_valid)
                    cmd = fdsc_pkg::CMD_LOAD;
            end
            fdsc_pkg::C_DECODE:
            begin
                if (status.out_free)
                begin
                    case (status.mode)
                        fdsc_pkg::MODE_WR_LEN:    cmd = fdsc_pkg::CMD_WR_LEN;
                        fdsc_pkg::MODE_WR_SYNC:   cmd = fdsc_pkg::CMD_WR_SYNC;
                        fdsc_pkg::MODE_RD_STATUS: cmd = fdsc_pkg::CMD_STATUS;
                        default:                  cmd = fdsc_pkg::CMD_NONE;
                    endcase
                end
            end
            fdsc_pkg::C_STEP_A:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_STEP_A;
            end
            fdsc_pkg::C_STEP_B:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_STEP_B;
            end
            fdsc_pkg::C_XFER:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_XFER;
            end
            fdsc_pkg::C_DONE:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_DONE;
            end
            fdsc_pkg::C_FLUSH:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_FLUSH;
            end
            fdsc_pkg::C_FIN:
            begin
                if (status.out_free)
                    cmd = fdsc_pkg::CMD_FIN;
            end
            default:
            begin
                cmd = fdsc_pkg::CMD_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fdsc_pkg::C_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_stall = state_reg != fdsc_pkg::C_IDLE;

endmodule

>>> rtl/core/floppy_dma_sync_controller_top.sv
// Top level of the floppy DMA sync controller: sequencer plus datapath.
//
// Usage:
//   in channel  (in_valid / in_stall / in_item): one item per register write,
//     status read, disk byte tick or DMA slot. in_stall is low only while the
//     block is idle, so one item is in work at a time.
//   out channel (out_valid / out_stall / out_item): zero to FIFO_BYTES + 3 result
//     items per input item; out_item.last marks the final result of each item.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): writes the
//     async_fifo, lock_sync and auto_sync bits; cfg_ready is always high.
//     Write configuration only while the block is idle.
// Sequence: an item is accepted, decoded and finished. A disk byte tick adds FIFO
//   step A when async_fifo was latched; a DMA slot adds steps A and B when it was
//   not, then a transfer; a completed block adds a done step and, for a write, a
//   FIFO flush. The sequencer runs one FIFO operation per cycle unless out_stall
//   holds a result; each result passes a one-deep hold stage and the output register.
// Stall: while out_stall holds a result, the sequencer freezes before any
//   step that could produce another result; nothing is dropped.
// Reset: rst_n is asynchronous, active low; DMA is off, the FIFO is empty,
//   the sync word is 0x4489 and async_fifo is set.
`include "floppy_dma_sync_controller_top_defines.svh"

module floppy_dma_sync_controller_top #(
    parameter int FIFO_BYTES = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fdsc_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output fdsc_pkg::out_item_t out_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic                cfg_data
);

    fdsc_pkg::cmd_t       cmd;
    fdsc_pkg::dp_status_t dp_status;

    // Configuration writes never wait.
    assign cfg_ready = 1'b1;

    fdsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (dp_status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    fdsc_dp #(
        .FIFO_BYTES (FIFO_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_item  (out_item),
        .status    (dp_status)
    );

    // Hold the input side busy right after an accept.
    `FDSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // Drop no result: an idle block has nothing waiting in the hold stage.
    `FDSC_ASSERT_NOW(a_idle_hold_empty, clk, rst_n, !in_stall, !dp_status.hold_valid)
    // Advance the datapath only when the output register can take a result.
    `FDSC_ASSERT_NOW(a_cmd_needs_room, clk, rst_n,
        cmd != fdsc_pkg::CMD_NONE && cmd != fdsc_pkg::CMD_LOAD, dp_status.out_free)

endmodule

>>> tb/fdsc_tb_pkg.sv
// Scoreboard for the floppy DMA sync controller: predicts results and checks them.
package fdsc_tb_pkg;
    timeunit 1ns;
    timeprecision 1ps;

    import fdsc_pkg::*;

    localparam int FIFO_DEPTH         = 6;
    localparam int MAX_RESULTS        = 10;

    // Modes the block decodes as no-ops
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Length register control bits
    localparam logic [15:0] LEN_ENABLE = 16'h8000;
    localparam logic [15:0] LEN_WRITE  = 16'h4000;

    class disk_dma_scoreboard;
        bit                    async_fifo_reg;
        bit                    lock_sync_reg;
        bit                    auto_sync_reg;
        dma_state_t            dma_state;
        bit [15:0]             length_reg;
        bit [15:0]             sync_word;
        bit [8*FIFO_DEPTH-1:0] fifo_bytes;
        int unsigned           fifo_fill;
        bit [7:0]              last_byte;
        bit [47:0]             last_byte_time;
        bit                    sync_seen;
        bit [14:0]             miss_count;
        bit                    async_latched;

        out_item_t             expected_results[$];
        out_item_t             item_results[$];
        int unsigned           failures;
        int unsigned           results_checked;
        int unsigned           kind_count[5];

        function new();
            async_fifo_reg = 1'b1;
            async_latched  = 1'b1;
            dma_state      = DMA_OFF;
            sync_word      = SYNC_DEFAULT;
        endfunction

        function void set_reg(logic [1:0] index, bit value);
            case (index)
                CFG_ASYNC_FIFO: async_fifo_reg = value;
                CFG_LOCK_SYNC:  lock_sync_reg  = value;
                CFG_AUTO_SYNC:  auto_sync_reg  = value;
                default: ;
            endcase
        endfunction

        function void add_result(logic [2:0] kind, logic [15:0] payload);
            out_item_t r;
            if (item_results.size() >= MAX_RESULTS)
                return;
            r.kind    = kind;
            r.payload = payload;
            r.last    = 1'b0;
            item_results.push_back(r);
        endfunction

        function void clear_fifo();
            fifo_bytes = '0;
            fifo_fill  = 0;
        endfunction

        // Drop the oldest two bytes when full, then shift the new byte in.
        function void push_byte(bit [7:0] b);
            if (fifo_fill >= FIFO_DEPTH)
                fifo_fill = FIFO_DEPTH - 2;
            fifo_bytes = {fifo_bytes[8*FIFO_DEPTH-9:0], b};
            fifo_fill++;
        endfunction

        function bit [7:0] pop_byte();
            if (fifo_fill == 0)
                return 8'h00;
            fifo_fill--;
            return fifo_bytes[8*fifo_fill +: 8];
        endfunction

        function bit [15:0] pop_word();
            if (fifo_fill < 2)
                return 16'h0000;
            fifo_fill -= 2;
            return fifo_bytes[8*fifo_fill +: 16];
        endfunction

        // One byte time under the head: shift in and hunt for sync, or feed the disk.
        function void head_step(bit [7:0] b, bit sel, bit [47:0] now);
            bit hit;
            if (!sel)
                return;
            if (dma_state != DMA_WRITE)
            begin
                last_byte      = b;
                last_byte_time = now;
                push_byte(b);
                sync_seen = (fifo_fill >= 2) && (fifo_bytes[15:0] == sync_word);
                hit = sync_seen;
                if (!hit && auto_sync_reg)
                begin
                    hit = miss_count > MISS_LIMIT;
                    miss_count++;
                end
                if (hit)
                begin
                    add_result(KIND_SYNC_IRQ, 16'h0000);
                    if (dma_state == DMA_WAIT)
                    begin
                        dma_state = DMA_READ;
                        clear_fifo();
                    end
                    miss_count = '0;
                end
            end
            else if (fifo_fill > 0)
            begin
                add_result(KIND_DISK_BYTE, {8'h00, pop_byte()});
            end
        endfunction

        function void slot_transfer(in_item_t it);
            if (!async_latched)
            begin
                head_step(it.drive_byte_a, it.drive_selected, it.now_clock);
                head_step(it.drive_byte_b, it.drive_selected, it.now_clock);
            end
            if (length_reg[13:0] == 0)
                return;
            if (dma_state != DMA_READ && dma_state != DMA_WRITE)
                return;
            if (!it.drive_selected)
                return;
            if (dma_state == DMA_READ)
            begin
                if (fifo_fill < 2)
                    return;
                add_result(KIND_MEM_WORD, pop_word());
                length_reg--;
                if (length_reg[13:0] == 0)
                begin
                    add_result(KIND_BLOCK_DONE, 16'h0000);
                    dma_state = DMA_OFF;
                end
            end
            else
            begin
                if (fifo_fill > FIFO_DEPTH - 2)
                    return;
                push_byte(it.mem_word[15:8]);
                push_byte(it.mem_word[7:0]);
                length_reg--;
                if (length_reg[13:0] == 0)
                begin
                    add_result(KIND_BLOCK_DONE, 16'h0000);
                    while (fifo_fill > 0)
                        add_result(KIND_DISK_BYTE, {8'h00, pop_byte()});
                    dma_state = DMA_OFF;
                end
            end
        endfunction

        function void note_item(in_item_t it);
            bit [15:0] prev_len;
            bit [15:0] status;
            item_results.delete();
            case (it.mode)
                MODE_WR_LEN:
                begin
                    prev_len      = length_reg;
                    length_reg    = it.reg_value;
                    async_latched = async_fifo_reg;
                    if (!it.reg_value[15])
                    begin
                        dma_state = DMA_OFF;
                        clear_fifo();
                    end
                    else if (prev_len[15])
                    begin
                        if (prev_len[14] && it.reg_value[14])
                            dma_state = DMA_WRITE;
                        else if (it.word_sync)
                            dma_state = DMA_WAIT;
                        else
                            dma_state = DMA_READ;
                        clear_fifo();
                    end
                end
                MODE_WR_SYNC:
                begin
                    if (!(lock_sync_reg && it.reg_value != SYNC_DEFAULT))
                        sync_word = it.reg_value;
                end
                MODE_RD_STATUS:
                begin
                    status = {8'h00, last_byte};
                    if (48'(it.now_clock - last_byte_time) <= AGE_LIMIT)
                        status[15] = 1'b1;
                    if (it.disk_dma_on && dma_state != DMA_OFF)
                        status[14] = 1'b1;
                    status[13] = length_reg[14];
                    status[12] = sync_seen;
                    add_result(KIND_STATUS, status);
                end
                MODE_DISK_TICK:
                begin
                    if (async_latched)
                        head_step(it.drive_byte_a, it.drive_selected, it.now_clock);
                end
                MODE_DMA_SLOT:
                    slot_transfer(it);
                default: ;
            endcase
            if (item_results.size() > 0)
                item_results[item_results.size() - 1].last = 1'b1;
            foreach (item_results[i])
                expected_results.push_back(item_results[i]);
        endfunction

        function void flag_field(string field, logic [15:0] want, logic [15:0] got);
            failures++;
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            results_checked++;
            if (got.kind <= KIND_DISK_BYTE)
                kind_count[got.kind]++;
            if (expected_results.size() == 0)
            begin
                failures++;
                $display("%0t ns: result with nothing pending, expected none, actual %h",
                         $time, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
                flag_field("kind", 16'(want.kind), 16'(got.kind));
            if (got.payload !== want.payload)
                flag_field("payload", want.payload, got.payload);
            if (got.last !== want.last)
                flag_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

endpackage

>>> tb/tb_top.sv
// Testbench top for the floppy DMA sync controller: drivers, monitor and run sequence.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fdsc_pkg::*;
    import fdsc_tb_pkg::*;

    // Slowest legal run stays well under this many cycles.
    localparam int unsigned CYCLE_LIMIT     = 1_000_000;
    // Longest item (slot plus write flush) plus the output stages, with margin.
    localparam int          SETTLE_CYCLES   = 24;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [1:0] cfg_index = CFG_ASYNC_FIFO;
    logic      cfg_data  = 1'b0;

    disk_dma_scoreboard dma_check = new();

    bit          no_idle       = 1'b0;
    bit [47:0]   master_clock  = '0;
    int unsigned items_sent    = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_count   = 0;

    floppy_dma_sync_controller_top #(
        .FIFO_BYTES(FIFO_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Hard stop: a hung handshake or a lost result ends here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL floppy_dma_sync_controller_top");
        $finish;
    end

    // Check every result item taken at a rising edge against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            dma_check.check_result(out_item);
    end

    // Result side: before each result draw a random stall, none while no_idle is set,
    // then hold stall low until one result is taken. A stall may start before valid
    // rises, so gaps land on every phase of the sequencer.
    initial
    begin
        int hold;
        forever
        begin
            hold = no_idle ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Present one input item after a random gap and hold it until taken.
    // Valid stays high across back-to-back items; it is only lowered for a gap.
    // The stamp on the item is the running master clock, which then creeps
    // forward a little, or now and then jumps to a random 48-bit value.
    task automatic put(input logic [2:0] mode, input logic [15:0] value,
                       input logic [7:0] byte_a, input logic [7:0] byte_b,
                       input logic sel, input logic ws);
        in_item_t it;
        int       gap;
        it.mode           = mode;
        it.reg_value      = value;
        it.word_sync      = ws;
        it.drive_selected = sel;
        it.drive_byte_a   = byte_a;
        it.drive_byte_b   = byte_b;
        it.mem_word       = value;
        it.now_clock      = master_clock;
        it.disk_dma_on    = 1'($urandom_range(0, 1));
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        dma_check.note_item(it);
        items_sent++;
        if ($urandom_range(0, 15) == 0)
            master_clock = {16'($urandom), 32'($urandom)};
        else
            master_clock += 48'($urandom_range(0, 5));
        @(negedge clk);
    endtask

    // Drop valid, wait out every pending result, then let the sequencer go idle.
    task automatic settle();
        in_valid <= 1'b0;
        while (dma_check.expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three control bits back to back while the block is idle.
    task automatic reconfigure(input bit async_fifo, input bit lock_sync, input bit auto_sync);
        logic [1:0] regs[3];
        bit         vals[3];
        regs = '{CFG_ASYNC_FIFO, CFG_LOCK_SYNC, CFG_AUTO_SYNC};
        vals = '{async_fifo, lock_sync, auto_sync};
        settle();
        cfg_valid <= 1'b1;
        foreach (regs[i])
        begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            dma_check.set_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // A well-formed block: arm the length register twice, optionally feed the
    // sync word, then a run of byte ticks, DMA slots and the odd status read.
    task automatic run_transfer();
        bit          to_disk;
        bit          ws;
        int          steps;
        int          pick;
        logic [15:0] len;
        logic [15:0] first_len;
        logic [13:0] count;
        to_disk = ($urandom_range(0, 2) == 0);
        ws      = 1'($urandom_range(0, 1));
        count   = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 5));
        len     = LEN_ENABLE | (to_disk ? LEN_WRITE : 16'h0000) | {2'b00, count};
        // On a read, bit 14 may appear on the first write only: it shows in status
        // but must not turn the block into a write.
        first_len = len | (($urandom_range(0, 1) == 1) ? LEN_WRITE : 16'h0000);
        put(MODE_WR_LEN, first_len, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), ws);
        put(MODE_WR_LEN, len, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)), ws);
        if (!to_disk && ws && $urandom_range(0, 4) != 0)
        begin
            if (dma_check.async_latched)
            begin
                put(MODE_DISK_TICK, 16'($urandom), dma_check.sync_word[15:8], 8'($urandom),
                    1'b1, 1'($urandom_range(0, 1)));
                put(MODE_DISK_TICK, 16'($urandom), dma_check.sync_word[7:0], 8'($urandom),
                    1'b1, 1'($urandom_range(0, 1)));
            end
            else
            begin
                put(MODE_DMA_SLOT, 16'($urandom), dma_check.sync_word[15:8],
                    dma_check.sync_word[7:0], 1'b1, 1'($urandom_range(0, 1)));
            end
        end
        steps = $urandom_range(3, 14);
        repeat (steps)
        begin
            pick = $urandom_range(0, 99);
            put(pick < 50 ? MODE_DISK_TICK : (pick < 92 ? MODE_DMA_SLOT : MODE_RD_STATUS),
                16'($urandom), 8'($urandom), 8'($urandom),
                $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
        end
    endtask

    // Mostly well-formed blocks, the rest noise, sync writes and disables.
    task automatic random_phase(input int unsigned n);
        int unsigned stop_at;
        int          pick;
        stop_at = items_sent + n;
        while (items_sent < stop_at)
        begin
            no_idle = ($urandom_range(0, 9) == 0);
            pick    = $urandom_range(0, 9);
            if (pick <= 5)
                run_transfer();
            else if (pick <= 7)
                put(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom), 8'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (pick == 8)
                put(MODE_WR_SYNC, ($urandom_range(0, 1) == 1) ? SYNC_DEFAULT : 16'($urandom),
                    8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
            else
                put(MODE_WR_LEN, 16'($urandom) & ~LEN_ENABLE, 8'($urandom), 8'($urandom),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        reconfigure(1'b1, 1'b0, 1'b0);

        // Directed: status out of reset, spare modes, sync register extremes.
        put(MODE_RD_STATUS, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_SPARE_LO, 16'hFFFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        put(MODE_SPARE_HI, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        put(MODE_WR_SYNC, 16'hFFFF, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_WR_SYNC, SYNC_DEFAULT, 8'h00, 8'h00, 1'b1, 1'b0);

        // Write block of four words: the first enable only stores the value.
        put(MODE_WR_LEN, 16'hC004, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_WR_LEN, 16'hC004, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'hFFFF, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'h5AA5, 8'h00, 8'h00, 1'b1, 1'b0);
        // FIFO holds six bytes: this slot has no room.
        put(MODE_DMA_SLOT, 16'h1234, 8'h00, 8'h00, 1'b1, 1'b0);
        // No drive selected: neither a slot nor a tick moves anything.
        put(MODE_DMA_SLOT, 16'h1234, 8'h00, 8'h00, 1'b0, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'h00, 8'h00, 1'b0, 1'b0);
        // Two bytes to disk, then the last word completes the block and flushes.
        put(MODE_DISK_TICK, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'h8001, 8'h00, 8'h00, 1'b1, 1'b0);

        // Read with word sync: wait for the sync word, then two words.
        put(MODE_WR_LEN, 16'h8002, 8'h00, 8'h00, 1'b1, 1'b1);
        master_clock = 48'h0000_0000_0100;
        put(MODE_DISK_TICK, 16'h0000, 8'h44, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'h89, 8'h00, 1'b1, 1'b0);
        // Clock behind the byte stamp: the age wraps and the byte is not fresh.
        master_clock = 48'h0000_0000_00FF;
        put(MODE_RD_STATUS, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'hAB, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        // FIFO empty: too few bytes for a word.
        put(MODE_DMA_SLOT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'hFF, 8'h00, 1'b1, 1'b0);
        put(MODE_DISK_TICK, 16'h0000, 8'hCD, 8'h00, 1'b1, 1'b0);
        put(MODE_DMA_SLOT, 16'h0000, 8'h00, 8'h00, 1'b1, 1'b0);

        // Random phases across the register settings, both extremes included.
        reconfigure(1'b1, 1'b1, 1'b1);
        random_phase(32);

        reconfigure(1'b0, 1'b0, 1'b1);
        random_phase(32);

        reconfigure(1'b0, 1'b0, 1'b0);
        random_phase(32);

        reconfigure(1'b1, 1'b0, 1'b1);
        random_phase(32);

        settle();

        $display("Sent %0d items over %0d register settings, directed write and read blocks first.",
                 items_sent, settings_used);
        $display("Checked %0d results: %0d status, %0d sync, %0d done, %0d words, %0d bytes.",
                 dma_check.results_checked, dma_check.kind_count[KIND_STATUS],
                 dma_check.kind_count[KIND_SYNC_IRQ], dma_check.kind_count[KIND_BLOCK_DONE],
                 dma_check.kind_count[KIND_MEM_WORD], dma_check.kind_count[KIND_DISK_BYTE]);
        if (dma_check.failures == 0 && dma_check.expected_results.size() == 0)
            $display("PASS floppy_dma_sync_controller_top");
        else
            $display("FAIL floppy_dma_sync_controller_top");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/fdsc_pkg.sv
rtl/core/fdsc_dp.sv
rtl/core/fdsc_ctrl.sv
rtl/core/floppy_dma_sync_controller_top.sv
tb/fdsc_tb_pkg.sv
tb/tb_top.sv
